// File: rtl/wvm_pkg.sv
package wvm_pkg;

    localparam int VOICES_DEF     = 8;
    localparam int TABLE_SIZE_DEF = 1024;

    localparam logic [15:0] GAIN_RESET = 16'd781;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef struct packed {
        logic [31:0] phase;
        logic [31:0] step;
        logic [23:0] remaining;
        logic        endless;
    } voice_rec_t;

    typedef struct packed {
        logic valid;
        logic act;
        logic last;
    } smp_ctl_t;

    typedef struct packed {
        logic done;
        logic clipped;
    } mix_res_t;

endpackage

// File: rtl/wvm_ram.sv
module wvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/wvm_interp.sv
module wvm_interp
    import wvm_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  smp_ctl_t           in_ctl,
    input  logic [31:0]        in_phase,
    output smp_ctl_t           out_ctl,
    output logic signed [15:0] out_sample
);

    localparam int L  = $clog2(TABLE_SIZE);
    localparam int QN = TABLE_SIZE / 4;
    localparam int JW = L - 1;

    // quarter-wave sine, q30 taylor series truncated per term, rounded half up
    function automatic logic [14:0] sine_quarter(input logic [63:0] j, input int sh);
        logic [63:0]        f;
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        f    = j << sh;
        a    = (f * 64'd1686629713) >> 30;
        a2   = (a * a) >> 30;
        term = a;
        sum  = signed'(a);
        term = ((term * a2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * a2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * a2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * a2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * a2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * a2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * a2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        term = ((term * a2) >> 30) / 64'd272;
        sum  = sum + signed'(term);
        if (sum < 64'sd0) begin
            sum = 64'sd0;
        end
        if (sum > 64'sd1073741824) begin
            sum = 64'sd1073741824;
        end
        v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

    logic [14:0] qrom [QN+1];

    for (genvar g = 0; g <= QN; g++) begin : g_qrom
        assign qrom[g] = sine_quarter(64'(g), 32 - L);
    end

    function automatic logic signed [15:0] table_entry(input logic [L-1:0] i);
        logic [JW-1:0] r;
        logic [JW-1:0] j;
        logic [15:0]   v;
        r = {1'b0, i[L-3:0]};
        j = i[L-2] ? (JW'(QN) - r) : r;
        v = {1'b0, qrom[j]};
        return signed'(i[L-1] ? (16'd0 - v) : v);
    endfunction

    logic [L-1:0]        idx;
    logic [L-1:0]        nidx;
    logic signed [15:0]  a_next;
    logic signed [15:0]  b_next;
    logic signed [15:0]  a_reg;
    logic signed [15:0]  b_reg;
    logic [15:0]         frac_reg;
    smp_ctl_t            ctl_a_reg;
    logic signed [16:0]  diff;
    logic signed [33:0]  prod;
    logic signed [33:0]  delta;
    logic signed [17:0]  interp;
    smp_ctl_t            ctl_b_reg;
    logic signed [15:0]  sample_reg;

    always_comb begin
        idx    = in_phase[31 -: L];
        nidx   = idx + L'(1);
        a_next = table_entry(idx);
        b_next = table_entry(nidx);
    end

    always_comb begin
        diff   = 17'(b_reg) - 17'(a_reg);
        prod   = diff * signed'({1'b0, frac_reg});
        delta  = prod >>> 16;
        interp = 18'(a_reg) + 18'(delta);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end else begin
            ctl_a_reg <= in_ctl;
            ctl_b_reg <= ctl_a_reg;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        frac_reg   <= in_phase[31-L -: 16];
        sample_reg <= interp[15:0];
    end

    assign out_ctl    = ctl_b_reg;
    assign out_sample = sample_reg;

endmodule

// File: rtl/wvm_mix.sv
module wvm_mix
    import wvm_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear,
    input  logic [15:0]        gain,
    input  smp_ctl_t           in_ctl,
    input  logic signed [15:0] in_sample,
    output mix_res_t           out_res,
    output logic signed [15:0] out_sample
);

    localparam int SUM_W  = 16 + $clog2(VOICES) + 1;
    localparam int PROD_W = SUM_W + 17;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-32768);
    localparam logic signed [PROD_W-1:0] ROUND  = PROD_W'(128);

    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] scaled;
    logic                     scale_reg;
    logic                     prod_valid_reg;
    mix_res_t                 res_reg;
    mix_res_t                 res_next;
    logic signed [15:0]       sample_reg;
    logic signed [15:0]       sample_next;

    always_comb begin
        sum_next = sum_reg;
        if (clear) begin
            sum_next = '0;
        end else if (in_ctl.valid && in_ctl.act) begin
            sum_next = sum_reg + SUM_W'(in_sample);
        end
    end

    always_comb begin
        scaled           = (prod_reg + ROUND) >>> 8;
        res_next.done    = prod_valid_reg;
        res_next.clipped = 1'b0;
        sample_next      = scaled[15:0];
        if (scaled > SAT_HI) begin
            sample_next      = 16'sh7fff;
            res_next.clipped = 1'b1;
        end else if (scaled < SAT_LO) begin
            sample_next      = -16'sh8000;
            res_next.clipped = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg      <= 1'b0;
            prod_valid_reg <= 1'b0;
            res_reg        <= '0;
        end else begin
            scale_reg      <= in_ctl.valid && in_ctl.last;
            prod_valid_reg <= scale_reg;
            res_reg        <= res_next;
        end
        sum_reg    <= sum_next;
        prod_reg   <= sum_reg * signed'({1'b0, gain});
        sample_reg <= sample_next;
    end

    assign out_res    = res_reg;
    assign out_sample = sample_reg;

endmodule

// File: rtl/wavetable_voice_mixer_core.sv
// channel | ports                          | direction | carries
// s       | s_valid, s_ready, s_func ...   | in        | start or tick item
// m       | m_valid, m_ready, m_mixed ...  | out       | one result item per input item
// cfg     | cfg_valid, cfg_ready, cfg_data | in        | output gain, unsigned q8.8
//
// a start item goes from idle straight to done; a tick item runs the voice scan
// through the single read port of the voice state memory, followed by
// the interpolation and gain pipeline
// synchronous active-low reset clears all voices and sets gain to 781
// a result waits in the output register; the next item is taken meanwhile
// and its result holds until the output register is free
module wavetable_voice_mixer_core
    import wvm_pkg::*;
#(
    parameter int VOICES     = VOICES_DEF,
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [31:0]        s_phase_step,
    input  logic [23:0]        s_duration_samples,
    input  logic               s_endless,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_mixed_sample,
    output logic               m_clipped,
    output logic               m_start_status,
    output logic [3:0]         m_active_voices,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW  = $clog2(VOICES + 1);
    localparam int REC_W = $bits(voice_rec_t);
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [VW-1:0]       scan_reg, scan_next;
    logic                iss_valid_reg, iss_valid_next;
    logic [VW-1:0]       iss_voice_reg, iss_voice_next;
    logic                iss_last_reg, iss_last_next;
    logic [VOICES-1:0]   active_reg, active_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [15:0]         gain_reg, gain_next;
    logic signed [15:0]  res_sample_reg, res_sample_next;
    logic                res_clip_reg, res_clip_next;
    logic                res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic signed [15:0]  m_sample_reg, m_sample_next;
    logic                m_clip_reg, m_clip_next;
    logic                m_status_reg, m_status_next;
    logic [3:0]          m_active_reg, m_active_next;

    logic                ram_we;
    logic [VW-1:0]       ram_waddr;
    voice_rec_t          ram_wdata;
    logic                ram_re;
    logic [REC_W-1:0]    ram_rdata;

    voice_rec_t          cur_rec;
    voice_rec_t          upd_rec;
    voice_rec_t          start_rec;
    logic                voice_act;
    logic                voice_stop;
    logic [23:0]         rem_dec;
    logic                start_want;
    logic                free_any;
    logic [VW-1:0]       free_idx;
    logic [CW+3:0]       cnt_ext;

    smp_ctl_t            int_in_ctl;
    smp_ctl_t            int_out_ctl;
    logic signed [15:0]  int_sample;
    logic                mix_clear;
    mix_res_t            mix_res;
    logic signed [15:0]  mix_sample;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cnt_ext   = {4'b0, cnt_reg};

    // lowest free voice
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!active_reg[v]) begin
                free_any = 1'b1;
                free_idx = VW'(v);
            end
        end
    end

    always_comb begin
        start_want          = s_endless || (s_duration_samples != 24'd0);
        start_rec.phase     = '0;
        start_rec.step      = s_phase_step;
        start_rec.remaining = s_endless ? 24'd0 : s_duration_samples;
        start_rec.endless   = s_endless;
    end

    // voice read-modify-write, in the cycle after the read
    always_comb begin
        cur_rec    = voice_rec_t'(ram_rdata);
        voice_act  = iss_valid_reg && active_reg[iss_voice_reg];
        rem_dec    = (cur_rec.remaining != 24'd0) ? cur_rec.remaining - 24'd1 : 24'd0;
        voice_stop = !cur_rec.endless && (rem_dec == 24'd0);
        upd_rec           = cur_rec;
        upd_rec.phase     = cur_rec.phase + cur_rec.step;
        upd_rec.remaining = cur_rec.endless ? cur_rec.remaining : rem_dec;
        int_in_ctl.valid  = iss_valid_reg;
        int_in_ctl.act    = voice_act;
        int_in_ctl.last   = iss_last_reg;
    end

    always_comb begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        iss_valid_next  = 1'b0;
        iss_voice_next  = scan_reg;
        iss_last_next   = 1'b0;
        active_next     = active_reg;
        cnt_next        = cnt_reg;
        gain_next       = gain_reg;
        res_sample_next = res_sample_reg;
        res_clip_next   = res_clip_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_sample_next   = m_sample_reg;
        m_clip_next     = m_clip_reg;
        m_status_next   = m_status_reg;
        m_active_next   = m_active_reg;
        ram_we          = 1'b0;
        ram_waddr       = iss_voice_reg;
        ram_wdata       = upd_rec;
        ram_re          = 1'b0;
        mix_clear       = 1'b0;

        if (cfg_valid) begin
            gain_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (voice_act) begin
            ram_we = 1'b1;
            if (voice_stop) begin
                active_next[iss_voice_reg] = 1'b0;
                cnt_next = cnt_reg - CW'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == FUNC_TICK) begin
                        state_next = ST_SCAN;
                        scan_next  = '0;
                        mix_clear  = 1'b1;
                    end else begin
                        res_sample_next = '0;
                        res_clip_next   = 1'b0;
                        res_status_next = start_want && !free_any;
                        if (start_want && free_any) begin
                            ram_we                = 1'b1;
                            ram_waddr             = free_idx;
                            ram_wdata             = start_rec;
                            active_next[free_idx] = 1'b1;
                            cnt_next              = cnt_reg + CW'(1);
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                ram_re         = 1'b1;
                iss_valid_next = 1'b1;
                iss_voice_next = scan_reg;
                iss_last_next  = (scan_reg == LAST_VOICE);
                if (scan_reg == LAST_VOICE) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_next = scan_reg + VW'(1);
                end
            end
            ST_DRAIN: begin
                if (mix_res.done) begin
                    res_sample_next = mix_sample;
                    res_clip_next   = mix_res.clipped;
                    res_status_next = 1'b0;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = res_sample_reg;
                    m_clip_next   = res_clip_reg;
                    m_status_next = res_status_reg;
                    m_active_next = cnt_ext[3:0];
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            iss_valid_reg <= 1'b0;
            iss_last_reg  <= 1'b0;
            active_reg    <= '0;
            cnt_reg       <= '0;
            gain_reg      <= GAIN_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            iss_valid_reg <= iss_valid_next;
            iss_last_reg  <= iss_last_next;
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            gain_reg      <= gain_next;
            m_valid_reg   <= m_valid_next;
        end
        iss_voice_reg  <= iss_voice_next;
        res_sample_reg <= res_sample_next;
        res_clip_reg   <= res_clip_next;
        res_status_reg <= res_status_next;
        m_sample_reg   <= m_sample_next;
        m_clip_reg     <= m_clip_next;
        m_status_reg   <= m_status_next;
        m_active_reg   <= m_active_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_mixed_sample  = m_sample_reg;
    assign m_clipped       = m_clip_reg;
    assign m_start_status  = m_status_reg;
    assign m_active_voices = m_active_reg;

    wvm_ram #(
        .WIDTH (REC_W),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    wvm_interp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_ctl     (int_in_ctl),
        .in_phase   (cur_rec.phase),
        .out_ctl    (int_out_ctl),
        .out_sample (int_sample)
    );

    wvm_mix #(
        .VOICES (VOICES)
    ) u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (mix_clear),
        .gain       (gain_reg),
        .in_ctl     (int_out_ctl),
        .in_sample  (int_sample),
        .out_res    (mix_res),
        .out_sample (mix_sample)
    );

`ifndef SYNTH
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(active_reg) == int'(cnt_reg))
        else $error("active count out of step with voice flags");

    a_mix_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        mix_res.done |-> state_reg == ST_DRAIN)
        else $error("mix result outside drain");

    a_no_rmw_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        iss_valid_reg |-> state_reg != ST_IDLE)
        else $error("voice write-back overlaps a start claim");

    a_result_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> state_reg == ST_IDLE)
        else $error("result loaded without returning to idle");
`endif

endmodule

// File: tb/tb.sv
module tb
    import wvm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVOICE      = VOICES_DEF;
    localparam int ROM_LEN     = TABLE_SIZE_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PHASE  = 155;

    localparam longint unsigned Q30_UNIT    = 64'd1073741824;
    localparam longint unsigned Q30_QUARTER = 64'd1686629713;

    typedef struct {
        logic        func;
        logic [31:0] step;
        logic [23:0] dur;
        logic        endless;
    } synth_item_t;

    typedef struct {
        logic signed [15:0] sample;
        logic               clipped;
        logic               status;
        logic [3:0]         active;
    } mix_out_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_func = FUNC_START;
    logic [31:0]        s_phase_step = '0;
    logic [23:0]        s_duration_samples = '0;
    logic               s_endless = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_mixed_sample;
    logic               m_clipped;
    logic               m_start_status;
    logic [3:0]         m_active_voices;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = '0;

    wavetable_voice_mixer_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_phase_step       (s_phase_step),
        .s_duration_samples (s_duration_samples),
        .s_endless          (s_endless),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_mixed_sample     (m_mixed_sample),
        .m_clipped          (m_clipped),
        .m_start_status     (m_start_status),
        .m_active_voices    (m_active_voices),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    // predictor state
    int          sine_rom [ROM_LEN];
    logic [31:0] voice_ph [NVOICE];
    logic [31:0] voice_inc [NVOICE];
    logic [23:0] voice_left [NVOICE];
    logic        voice_loop [NVOICE];
    logic        voice_on [NVOICE];
    logic [15:0] gain_q88 = GAIN_RESET;

    synth_item_t item_q [$];
    mix_out_t    mix_due_q [$];
    synth_item_t cur_item;
    mix_out_t    want;

    int cyc = 0;
    int err_count = 0;
    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_starts = 0;
    int n_refused = 0;
    int n_ticks = 0;
    int n_clips = 0;
    int n_gains = 0;
    int loop_budget = 1;
    logic calm;

    assign calm = ((cyc / 3000) % 4) == 2;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int sine_q15(int unsigned idx);
        longint unsigned u, f, a, a2, term;
        longint          acc;
        int unsigned     quad;
        int              v;
        u    = (longint'(idx) << 32) / ROM_LEN;
        quad = int'((u >> 30) & 64'd3);
        f    = u & (Q30_UNIT - 1);
        if (quad & 1) begin
            f = Q30_UNIT - f;
        end
        a    = (f * Q30_QUARTER) >> 30;
        a2   = (a * a) >> 30;
        term = a;
        acc  = longint'(a);
        for (int k = 1; k <= 8; k++) begin
            term = ((term * a2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k & 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(Q30_UNIT)) begin
            acc = longint'(Q30_UNIT);
        end
        v = int'((acc * 32767 + (longint'(1) << 29)) >> 30);
        if (v > 32767) begin
            v = 32767;
        end
        return (quad >= 2) ? -v : v;
    endfunction

    // linear interpolation between neighboring rom entries, floored
    function automatic int voice_value(logic [31:0] ph);
        logic [9:0] idx, nxt;
        longint     fr, d;
        idx = ph[31:22];
        nxt = idx + 10'd1;
        fr  = longint'(ph[21:6]);
        d   = longint'(sine_rom[nxt] - sine_rom[idx]) * fr;
        return sine_rom[idx] + int'(d >>> 16);
    endfunction

    function automatic mix_out_t mix_step(synth_item_t it);
        mix_out_t r;
        longint   acc, g, sc;
        int       cnt;
        r   = '{sample: '0, clipped: 1'b0, status: 1'b0, active: '0};
        acc = 0;
        if (it.func == FUNC_START) begin
            if (it.endless || it.dur != '0) begin
                r.status = 1'b1;
                for (int v = 0; v < NVOICE; v++) begin
                    if (!voice_on[v]) begin
                        voice_on[v]   = 1'b1;
                        voice_ph[v]   = '0;
                        voice_inc[v]  = it.step;
                        voice_loop[v] = it.endless;
                        voice_left[v] = it.endless ? 24'd0 : it.dur;
                        r.status      = 1'b0;
                        break;
                    end
                end
            end
        end else begin
            for (int v = 0; v < NVOICE; v++) begin
                if (voice_on[v]) begin
                    acc = acc + voice_value(voice_ph[v]);
                    voice_ph[v] = voice_ph[v] + voice_inc[v];
                    if (!voice_loop[v]) begin
                        if (voice_left[v] != '0) begin
                            voice_left[v] = voice_left[v] - 24'd1;
                        end
                        if (voice_left[v] == '0) begin
                            voice_on[v] = 1'b0;
                        end
                    end
                end
            end
            g  = longint'(gain_q88);
            sc = (acc * g + 128) >>> 8;
            if (sc > 32767) begin
                sc        = 32767;
                r.clipped = 1'b1;
            end else if (sc < -32768) begin
                sc        = -32768;
                r.clipped = 1'b1;
            end
            r.sample = sc[15:0];
        end
        cnt = 0;
        for (int v = 0; v < NVOICE; v++) begin
            cnt += voice_on[v] ? 1 : 0;
        end
        r.active = cnt[3:0];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        err_count++;
        $display("mismatch at cycle %0d: %s", cyc, what);
    endtask

    task automatic queue_item(logic func, logic [31:0] step, logic [23:0] dur, logic endless);
        synth_item_t it;
        it.func    = func;
        it.step    = step;
        it.dur     = dur;
        it.endless = endless;
        item_q.push_back(it);
        n_queued++;
    endtask

    task automatic write_gain(logic [15:0] g);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        gain_q88 = g;
        n_gains++;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (n_accepted != n_queued || mix_due_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // bursts of starts and ticks; ticks carry junk in the unused fields
    task automatic queue_random(int n);
        logic        endl;
        logic [23:0] dur;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 28) begin
                endl = 1'b0;
                if (loop_budget > 0 && $urandom_range(199) == 0) begin
                    endl = 1'b1;
                    loop_budget--;
                end
                if (endl) begin
                    dur = 24'($urandom());
                end else if ($urandom_range(99) < 8) begin
                    dur = '0;
                end else begin
                    dur = 24'($urandom_range(48, 1));
                end
                queue_item(FUNC_START, $urandom(), dur, endl);
            end else begin
                queue_item(FUNC_TICK, $urandom(), 24'($urandom()), 1'($urandom_range(1)));
            end
        end
    endtask

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("tb failed");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                mix_due_q.push_back(mix_step(cur_item));
                n_accepted++;
            end
            if ((!s_valid || s_ready) && item_q.size() != 0
                    && (calm || $urandom_range(99) >= 7)) begin
                cur_item = item_q.pop_front();
                s_valid            <= 1'b1;
                s_func             <= cur_item.func;
                s_phase_step       <= cur_item.step;
                s_duration_samples <= cur_item.dur;
                s_endless          <= cur_item.endless;
            end else if (s_valid && s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (mix_due_q.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want = mix_due_q.pop_front();
                    if (m_mixed_sample !== want.sample) begin
                        report_mismatch($sformatf("item %0d mixed_sample %0d, expected %0d",
                            n_results, m_mixed_sample, want.sample));
                    end
                    if (m_clipped !== want.clipped) begin
                        report_mismatch($sformatf("item %0d clipped %b, expected %b",
                            n_results, m_clipped, want.clipped));
                    end
                    if (m_start_status !== want.status) begin
                        report_mismatch($sformatf("item %0d start_status %b, expected %b",
                            n_results, m_start_status, want.status));
                    end
                    if (m_active_voices !== want.active) begin
                        report_mismatch($sformatf("item %0d active_voices %0d, expected %0d",
                            n_results, m_active_voices, want.active));
                    end
                    n_clips   += want.clipped ? 1 : 0;
                    n_refused += want.status ? 1 : 0;
                    n_results++;
                end
            end
            m_ready <= calm || $urandom_range(99) >= 7;
        end
    end

    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            if (s_func == FUNC_START) begin
                n_starts++;
            end else begin
                n_ticks++;
            end
        end
    end

    initial begin
        logic [15:0] gain_set [7];
        for (int i = 0; i < ROM_LEN; i++) begin
            sine_rom[i] = sine_q15(i);
        end
        for (int v = 0; v < NVOICE; v++) begin
            voice_ph[v]   = '0;
            voice_inc[v]  = '0;
            voice_left[v] = '0;
            voice_loop[v] = 1'b0;
            voice_on[v]   = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty mix, zero duration, endless, extremes, full voice pool
        queue_item(FUNC_TICK,  32'h0000_0000, 24'h000000, 1'b0);
        queue_item(FUNC_START, 32'hFFFF_FFFF, 24'h000000, 1'b0);
        queue_item(FUNC_START, 32'h00A0_0000, 24'h000000, 1'b1);
        queue_item(FUNC_START, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b0);
        queue_item(FUNC_START, 32'h0000_0000, 24'h000003, 1'b0);
        queue_item(FUNC_START, 32'h0040_0000, 24'h000002, 1'b0);
        queue_item(FUNC_START, 32'h0000_0040, 24'h000001, 1'b0);
        queue_item(FUNC_START, 32'h4000_0000, 24'h000005, 1'b0);
        queue_item(FUNC_START, 32'h8000_0000, 24'h000004, 1'b0);
        queue_item(FUNC_START, 32'h1234_5678, 24'h000006, 1'b0);
        queue_item(FUNC_START, 32'hC000_0000, 24'h000007, 1'b1);
        repeat (9) begin
            queue_item(FUNC_TICK, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b1);
        end
        queue_item(FUNC_START, 32'h2000_0000, 24'h000002, 1'b0);
        queue_item(FUNC_TICK,  32'h0000_0000, 24'h000000, 1'b0);
        queue_item(FUNC_TICK,  32'h0000_0000, 24'h000000, 1'b0);
        wait_drained();

        gain_set = '{16'hFFFF, 16'h0000, 16'h0100, 16'h0000, 16'h0001, 16'h0000, GAIN_RESET};
        gain_set[3] = 16'($urandom_range(65535));
        gain_set[5] = 16'($urandom_range(65535));
        foreach (gain_set[p]) begin
            write_gain(gain_set[p]);
            queue_random(RAND_PHASE);
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        $display("%0d items checked: %0d starts (%0d refused), %0d ticks, %0d clipped",
            n_results, n_starts, n_refused, n_ticks, n_clips);
        $display("%0d gain settings written, %0d mismatches", n_gains, err_count);
        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
